### hdl/gcd_pkg.sv
// Shared constants and fixed-point helpers for the great-circle distance core.
// Depends on nothing; used by great_circle_distance_core.
`default_nettype none

package gcd_pkg;

    localparam int ROTATION_STEPS = 28;
    localparam int SQRT_STEPS     = 31;

    localparam logic [63:0] PI_Q60        = 64'h3243F6A8885A308D;
    localparam logic [63:0] UDEG_TO_RAD   = PI_Q60 / 64'd180000000;
    localparam logic [16:0] UDEG_RAD_HI   = UDEG_TO_RAD[34:18];
    localparam logic [17:0] UDEG_RAD_LO   = UDEG_TO_RAD[17:0];
    localparam logic [31:0] PI_Q30        = PI_Q60[61:30];
    localparam logic [31:0] HALF_PI_Q30   = PI_Q60[62:31];
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [30:0] ONE_Q30       = 31'h40000000;
    localparam logic [23:0] DIAMETER_M    = 24'd12742000;
    localparam logic [24:0] MAX_DISTANCE  = 25'd20015087;
    localparam logic signed [28:0] LAT_LIMIT = 29'sd90000000;
    localparam logic signed [28:0] LON_LIMIT = 29'sd180000000;

    function automatic logic signed [28:0] clamp_coord(logic signed [28:0] v,
                                                       logic signed [28:0] lim);
        logic signed [28:0] r;
        r = v;
        if (v > lim) r = lim;
        if (v < -lim) r = -lim;
        return r;
    endfunction

    function automatic logic [28:0] abs_mag(logic signed [29:0] v);
        logic signed [29:0] n;
        n = -v;
        return v[29] ? n[28:0] : v[28:0];
    endfunction

    function automatic logic signed [33:0] atan_q30(int i);
        logic signed [33:0] r;
        case (i)
            0:       r = 34'h3243F6A8;
            1:       r = 34'h1DAC6705;
            2:       r = 34'h0FADBAFC;
            3:       r = 34'h07F56EA6;
            4:       r = 34'h03FEAB76;
            5:       r = 34'h01FFD55B;
            6:       r = 34'h00FFFAAA;
            7:       r = 34'h007FFF55;
            8:       r = 34'h003FFFEA;
            9:       r = 34'h001FFFFD;
            10:      r = 34'h000FFFFF;
            default: r = (i < 30) ? ((34'sd1 <<< (30 - i)) - 34'sd1) : 34'sd0;
        endcase
        return r;
    endfunction

    function automatic logic [30:0] clamp_unit(logic signed [33:0] v);
        logic [30:0] r;
        if (v < 0)
            r = '0;
        else if (v > $signed({3'b000, ONE_Q30}))
            r = ONE_Q30;
        else
            r = v[30:0];
        return r;
    endfunction

    // Q30 product, rounded half up; operands lie in [0, 1]
    function automatic logic [30:0] mul_q30(logic [30:0] a, logic [30:0] b);
        logic [61:0] p;
        p = 62'(a) * 62'(b) + (62'd1 << 29);
        return p[60:30];
    endfunction

endpackage

`default_nettype wire

### hdl/great_circle_distance_core.sv
// Pipelined haversine great-circle distance core.
// Depends on gcd_pkg (constants, CORDIC arctangent table, Q30 helpers).
`default_nettype none

// Usage
//   Slave side: one transfer carries two points, latitude and longitude in
//   signed microdegrees. Master side: one transfer per input with the
//   distance in whole meters, clamped to half the circumference.
//   A result passes the input, radian, CORDIC, haversine, square root,
//   vectoring and scaling registers until it sits in the output buffer with
//   m_tvalid high; the earliest output transfer is at the following edge.
//   Throughput: one transfer per cycle while the output buffer has room.
//   Every CORDIC iteration, every square root digit and every multiply
//   ends in a register, so the rate is set by the stage advance.
//   Reset: clears all valid bits and empties the two-entry output buffer;
//   data registers are not reset.
//   Receiver stall: results collect in a two-entry output buffer while the
//   pipeline keeps running; once both entries are full the pipeline holds
//   and s_tready drops, so no result is lost or repeated.
//   Out-of-range coordinates saturate to the legal range before use.
//   CORDIC, haversine, integer square root and vectoring CORDIC follow in
//   order; the final stage scales the central half angle by the earth diameter.
module great_circle_distance_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // first_latitude[27:0], first_longitude[56:28], second_latitude[84:57],
    // second_longitude[113:85], zero fill [119:114]
    input  logic [119:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // distance_meters[24:0], zero fill [31:25]
    output logic [31:0]  m_tdata
);

    localparam int N     = gcd_pkg::ROTATION_STEPS;
    localparam int NSQ   = gcd_pkg::SQRT_STEPS;
    localparam int S_ROT = 3;
    localparam int S_M4  = S_ROT + N + 3;
    localparam int S_SQ  = S_M4 + 1;
    localparam int S_VEC = S_SQ + NSQ;
    localparam int S_MUL = S_VEC + N;
    localparam int L     = S_MUL + 1;

    logic         en;
    logic [L-1:0] vld_reg;
    logic         push;
    logic         pop;
    logic [1:0]   cnt_reg;

    // Hold every stage when the output buffer is full.
    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[L-2:0], s_tvalid};
        end
    end

    // ---------------------------------------------------------------
    // Stage 0: saturate coordinates, form differences and magnitudes
    // ---------------------------------------------------------------
    logic signed [28:0] lat1_c, lon1_c, lat2_c, lon2_c;
    logic [28:0]        mag_reg [4];

    always_comb
    begin
        lat1_c = gcd_pkg::clamp_coord({s_tdata[27], s_tdata[27:0]}, gcd_pkg::LAT_LIMIT);
        lon1_c = gcd_pkg::clamp_coord(s_tdata[56:28], gcd_pkg::LON_LIMIT);
        lat2_c = gcd_pkg::clamp_coord({s_tdata[84], s_tdata[84:57]}, gcd_pkg::LAT_LIMIT);
        lon2_c = gcd_pkg::clamp_coord(s_tdata[113:85], gcd_pkg::LON_LIMIT);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg[0] <= gcd_pkg::abs_mag(30'(lat2_c) - 30'(lat1_c));
            mag_reg[1] <= gcd_pkg::abs_mag(30'(lon2_c) - 30'(lon1_c));
            mag_reg[2] <= gcd_pkg::abs_mag(30'(lat1_c));
            mag_reg[3] <= gcd_pkg::abs_mag(30'(lat2_c));
        end
    end

    // ---------------------------------------------------------------
    // Stages 1-2: microdegrees to Q30 radians, constant split in halves
    // ---------------------------------------------------------------
    logic [45:0] pph_reg [4];
    logic [46:0] ppl_reg [4];
    logic [31:0] ang_reg [4];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int u = 0; u < 4; u++)
            begin
                pph_reg[u] <= 46'(mag_reg[u]) * 46'(gcd_pkg::UDEG_RAD_HI);
                ppl_reg[u] <= 47'(mag_reg[u]) * 47'(gcd_pkg::UDEG_RAD_LO);
            end
        end
    end

    logic [63:0] full [4];
    logic [31:0] ang_next [4];

    always_comb
    begin
        for (int u = 0; u < 4; u++)
        begin
            full[u] = {pph_reg[u], 18'b0} + 64'(ppl_reg[u]);
        end
        // half angle differences: fold above pi/2 onto pi minus itself
        for (int u = 0; u < 2; u++)
        begin
            ang_next[u] = full[u][62:31] + 32'(full[u][30]);
            if (ang_next[u] > gcd_pkg::HALF_PI_Q30)
                ang_next[u] = gcd_pkg::PI_Q30 - ang_next[u];
        end
        for (int u = 2; u < 4; u++)
        begin
            ang_next[u] = full[u][61:30] + 32'(full[u][29]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg <= ang_next;
        end
    end

    // ---------------------------------------------------------------
    // Rotation CORDIC: four lanes, one iteration per stage
    // ---------------------------------------------------------------
    logic signed [33:0] rx_reg [N][4];
    logic signed [33:0] ry_reg [N][4];
    logic signed [33:0] rz_reg [N][4];

    for (genvar i = 0; i < N; i++)
    begin : g_rot
        for (genvar u = 0; u < 4; u++)
        begin : g_lane
            logic signed [33:0] xi, yi, zi;
            if (i == 0)
            begin : g_first
                assign xi = gcd_pkg::CORDIC_GAIN;
                assign yi = '0;
                assign zi = $signed({2'b00, ang_reg[u]});
            end
            else
            begin : g_next
                assign xi = rx_reg[i-1][u];
                assign yi = ry_reg[i-1][u];
                assign zi = rz_reg[i-1][u];
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (zi >= 0)
                    begin
                        rx_reg[i][u] <= xi - (yi >>> i);
                        ry_reg[i][u] <= yi + (xi >>> i);
                        rz_reg[i][u] <= zi - gcd_pkg::atan_q30(i);
                    end
                    else
                    begin
                        rx_reg[i][u] <= xi + (yi >>> i);
                        ry_reg[i][u] <= yi - (xi >>> i);
                        rz_reg[i][u] <= zi + gcd_pkg::atan_q30(i);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Haversine term a: both squares in the first stage, then one multiply per stage
    // ---------------------------------------------------------------
    logic [30:0] sl2_reg, sa2_m1_reg, c1_reg, c2_m1_reg;
    logic [30:0] t1_reg, sa2_m2_reg, c2_m2_reg;
    logic [30:0] t_reg, sa2_m3_reg;
    logic [30:0] a_reg;
    logic [31:0] a_sum;

    always_comb
    begin
        a_sum = 32'(sa2_m3_reg) + 32'(t_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sl2_reg    <= gcd_pkg::mul_q30(gcd_pkg::clamp_unit(ry_reg[N-1][1]),
                                           gcd_pkg::clamp_unit(ry_reg[N-1][1]));
            sa2_m1_reg <= gcd_pkg::mul_q30(gcd_pkg::clamp_unit(ry_reg[N-1][0]),
                                           gcd_pkg::clamp_unit(ry_reg[N-1][0]));
            c1_reg     <= gcd_pkg::clamp_unit(rx_reg[N-1][2]);
            c2_m1_reg  <= gcd_pkg::clamp_unit(rx_reg[N-1][3]);
            t1_reg     <= gcd_pkg::mul_q30(sl2_reg, c1_reg);
            sa2_m2_reg <= sa2_m1_reg;
            c2_m2_reg  <= c2_m1_reg;
            t_reg      <= gcd_pkg::mul_q30(t1_reg, c2_m2_reg);
            sa2_m3_reg <= sa2_m2_reg;
            a_reg      <= (a_sum > 32'(gcd_pkg::ONE_Q30)) ? gcd_pkg::ONE_Q30 : a_sum[30:0];
        end
    end

    // ---------------------------------------------------------------
    // Integer square roots of a and 1-a (Q60 in, Q30 out), one digit a stage
    // ---------------------------------------------------------------
    logic [61:0] sv_reg [NSQ][2];
    logic [61:0] sr_reg [NSQ][2];

    for (genvar j = 0; j < NSQ; j++)
    begin : g_sqrt
        for (genvar u = 0; u < 2; u++)
        begin : g_unit
            logic [61:0] vi, ri, trial;
            if (j == 0)
            begin : g_first
                if (u == 0)
                begin : g_a
                    assign vi = {1'b0, a_reg, 30'b0};
                end
                else
                begin : g_rest
                    assign vi = {1'b0, gcd_pkg::ONE_Q30 - a_reg, 30'b0};
                end
                assign ri = '0;
            end
            else
            begin : g_next
                assign vi = sv_reg[j-1][u];
                assign ri = sr_reg[j-1][u];
            end
            assign trial = ri + (62'd1 << (2 * (NSQ - 1 - j)));
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (vi >= trial)
                    begin
                        sv_reg[j][u] <= vi - trial;
                        sr_reg[j][u] <= (ri >> 1) + (62'd1 << (2 * (NSQ - 1 - j)));
                    end
                    else
                    begin
                        sv_reg[j][u] <= vi;
                        sr_reg[j][u] <= ri >> 1;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Vectoring CORDIC: central half angle atan2(sqrt(a), sqrt(1-a))
    // ---------------------------------------------------------------
    logic signed [33:0] vx_reg [N];
    logic signed [33:0] vy_reg [N];
    logic signed [33:0] vz_reg [N];

    for (genvar j = 0; j < N; j++)
    begin : g_vec
        logic signed [33:0] xi, yi, zi;
        if (j == 0)
        begin : g_first
            assign xi = $signed({3'b000, sr_reg[NSQ-1][1][30:0]});
            assign yi = $signed({3'b000, sr_reg[NSQ-1][0][30:0]});
            assign zi = '0;
        end
        else
        begin : g_next
            assign xi = vx_reg[j-1];
            assign yi = vy_reg[j-1];
            assign zi = vz_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (yi >= 0)
                begin
                    vx_reg[j] <= xi + (yi >>> j);
                    vy_reg[j] <= yi - (xi >>> j);
                    vz_reg[j] <= zi + gcd_pkg::atan_q30(j);
                end
                else
                begin
                    vx_reg[j] <= xi - (yi >>> j);
                    vy_reg[j] <= yi + (xi >>> j);
                    vz_reg[j] <= zi - gcd_pkg::atan_q30(j);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Scale by the diameter; drop negative angles to zero
    // ---------------------------------------------------------------
    logic [32:0] z_pos;
    logic [56:0] prod_reg;
    logic [56:0] prod_rnd;
    logic [24:0] meters;

    assign z_pos = vz_reg[N-1][33] ? 33'd0 : vz_reg[N-1][32:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 57'(z_pos) * 57'(gcd_pkg::DIAMETER_M);
        end
    end

    always_comb
    begin
        prod_rnd = prod_reg + (57'd1 << 29);
        if (prod_rnd[56:30] > 27'(gcd_pkg::MAX_DISTANCE))
            meters = gcd_pkg::MAX_DISTANCE;
        else
            meters = prod_rnd[54:30];
    end

    // ---------------------------------------------------------------
    // Two-entry output buffer
    // ---------------------------------------------------------------
    logic [24:0] d0_reg, d1_reg;

    assign push     = en && vld_reg[L-1];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {7'b0, d0_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            cnt_reg <= cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && pop)
        begin
            if (cnt_reg == 2'd1)
                d0_reg <= meters;
            else
            begin
                d0_reg <= d1_reg;
                d1_reg <= meters;
            end
        end
        else if (push)
        begin
            if (cnt_reg == 2'd0)
                d0_reg <= meters;
            else
                d1_reg <= meters;
        end
        else if (pop)
        begin
            d0_reg <= d1_reg;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_dist_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[24:0] <= gcd_pkg::MAX_DISTANCE))
        else $error("distance above half circumference");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1))
        else $error("buffer count did not advance on push");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while buffer full");

    a_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_VEC-1] |-> (sr_reg[NSQ-1][0] <= 62'(gcd_pkg::ONE_Q30)))
        else $error("square root of a above one");

endmodule

`default_nettype wire
